>>> rtl/sem_pkg.sv
// sem_pkg: widths, word types and register codes for the segment edge matcher
// depends on nothing; used by every module under rtl
package sem_pkg;

  localparam int NODE_ID_BITS = 20;
  localparam int CRD_W = 32;
  localparam int DIF_W = CRD_W + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int DOT_W = PRD_W + 1;
  localparam int SQ_W = 136;
  localparam int TOL_W = 31;
  localparam int MAT_W = 16;
  localparam int NRM_W = DOT_W;
  localparam int TN_W = 98;
  localparam int TSQ_W = 129;
  localparam int SD_W = 100;
  localparam int QF = 16;
  localparam int IDX_W = 3;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  typedef enum logic [IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5,
    REG_TOL     = 3'd6,
    REG_MAT     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [NODE_ID_BITS-1:0] edge_first_id;
    logic [NODE_ID_BITS-1:0] edge_second_id;
    logic signed [CRD_W-1:0] edge_first_x;
    logic signed [CRD_W-1:0] edge_first_y;
    logic signed [CRD_W-1:0] edge_first_z;
    logic signed [CRD_W-1:0] edge_second_x;
    logic signed [CRD_W-1:0] edge_second_y;
    logic signed [CRD_W-1:0] edge_second_z;
  } edge_word_t;

  typedef struct packed {
    logic                    matched;
    logic [NODE_ID_BITS-1:0] line_start_id;
    logic [NODE_ID_BITS-1:0] line_end_id;
    logic [MAT_W-1:0]        line_material;
  } result_word_t;

  typedef struct packed {
    logic [CRD_W-1:0] sx;
    logic [CRD_W-1:0] sy;
    logic [CRD_W-1:0] sz;
    logic [DIF_W-1:0] wx;
    logic [DIF_W-1:0] wy;
    logic [DIF_W-1:0] wz;
  } sem_seg_t;

  typedef struct packed {
    logic              norm_zero;
    logic [TSQ_W-1:0]  tsqn;
    logic [SD_W-1:0]   lo;
    logic [SD_W-1:0]   hi;
  } sem_bnd_t;

endpackage

>>> rtl/sem_cfg.sv
// sem_cfg: register file and the pipelined bounds derived from the segment
// depends on sem_pkg
module sem_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [sem_pkg::IDX_W-1:0] wr_index,
  input  logic [31:0]           wr_data,
  output sem_pkg::sem_seg_t     seg,
  output sem_pkg::sem_bnd_t     bnd,
  output logic [sem_pkg::MAT_W-1:0] material
);
  import sem_pkg::*;

  logic signed [CRD_W-1:0] sx, sy, sz, ex, ey, ez;
  logic [TOL_W-1:0] tol;

  logic signed [DIF_W-1:0] wx, wy, wz;
  logic [TOL_W-1:0] tol1, tol2, tol3;
  logic [PRD_W-1:0] qx, qy, qz;
  logic [2*TOL_W-1:0] tsq2, tsq3;
  logic [NRM_W-1:0] norm3, norm4, norm5;
  logic [65:0] tnh;
  logic [62:0] tnl;
  logic [64:0] thnh;
  logic [61:0] thnl;
  logic [66:0] tlnh;
  logic [63:0] tlnl;
  logic [TN_W-1:0] tolnorm;
  logic [TSQ_W-1:0] tsqn5;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; sz <= '0;
      ex <= '0; ey <= '0; ez <= '0;
      tol <= TOL_RESET;
      material <= '0;
    end else if (wr) begin
      case (cfg_reg_t'(wr_index))
        REG_START_X: sx <= wr_data;
        REG_START_Y: sy <= wr_data;
        REG_START_Z: sz <= wr_data;
        REG_END_X:   ex <= wr_data;
        REG_END_Y:   ey <= wr_data;
        REG_END_Z:   ez <= wr_data;
        REG_TOL:     tol <= wr_data[TOL_W-1:0];
        REG_MAT:     material <= wr_data[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wx <= {ex[CRD_W-1], ex} - {sx[CRD_W-1], sx};
    wy <= {ey[CRD_W-1], ey} - {sy[CRD_W-1], sy};
    wz <= {ez[CRD_W-1], ez} - {sz[CRD_W-1], sz};
    tol1 <= tol;
    qx <= PRD_W'(wx * wx);
    qy <= PRD_W'(wy * wy);
    qz <= PRD_W'(wz * wz);
    tsq2 <= tol1 * tol1;
    tol2 <= tol1;
    norm3 <= NRM_W'(qx) + NRM_W'(qy) + NRM_W'(qz);
    tsq3 <= tsq2;
    tol3 <= tol2;
    tnh <= tol3 * norm3[NRM_W-1:32];
    tnl <= tol3 * norm3[31:0];
    thnh <= tsq3[61:32] * norm3[NRM_W-1:32];
    thnl <= tsq3[61:32] * norm3[31:0];
    tlnh <= tsq3[31:0] * norm3[NRM_W-1:32];
    tlnl <= tsq3[31:0] * norm3[31:0];
    norm4 <= norm3;
    tolnorm <= {tnh, 32'b0} + TN_W'(tnl);
    tsqn5 <= {thnh, 64'b0} + TSQ_W'({thnl, 32'b0}) + TSQ_W'({tlnh, 32'b0})
             + TSQ_W'(tlnl);
    norm5 <= norm4;
    bnd.norm_zero <= (norm5 == '0);
    bnd.tsqn <= tsqn5;
    bnd.lo <= SD_W'(0) - SD_W'(tolnorm);
    bnd.hi <= SD_W'({norm5, 16'b0}) + SD_W'(tolnorm);
  end

  assign seg.sx = sx;
  assign seg.sy = sy;
  assign seg.sz = sz;
  assign seg.wx = wx;
  assign seg.wy = wy;
  assign seg.wz = wz;

endmodule

>>> rtl/sem_proj.sv
// sem_proj: endpoint offsets, dot products and cross products, three stages
// depends on sem_pkg
module sem_proj (
  input  logic                      clk,
  input  sem_pkg::sem_seg_t         seg,
  input  sem_pkg::edge_word_t       word,
  output logic signed [sem_pkg::DOT_W-1:0] dot1,
  output logic signed [sem_pkg::DOT_W-1:0] dot2,
  output logic signed [sem_pkg::DOT_W-1:0] crs [6]
);
  import sem_pkg::*;

  logic signed [DIF_W-1:0] d [6];
  logic signed [DIF_W-1:0] w [3];
  logic signed [PRD_W-1:0] md [6];
  logic signed [PRD_W-1:0] ma [6];
  logic signed [PRD_W-1:0] mb [6];

  assign w[0] = $signed(seg.wx);
  assign w[1] = $signed(seg.wy);
  assign w[2] = $signed(seg.wz);

  // endpoint offsets from the segment start
  always_ff @(posedge clk) begin
    d[0] <= {word.edge_first_x[CRD_W-1], word.edge_first_x} - $signed({seg.sx[CRD_W-1], seg.sx});
    d[1] <= {word.edge_first_y[CRD_W-1], word.edge_first_y} - $signed({seg.sy[CRD_W-1], seg.sy});
    d[2] <= {word.edge_first_z[CRD_W-1], word.edge_first_z} - $signed({seg.sz[CRD_W-1], seg.sz});
    d[3] <= {word.edge_second_x[CRD_W-1], word.edge_second_x} - $signed({seg.sx[CRD_W-1], seg.sx});
    d[4] <= {word.edge_second_y[CRD_W-1], word.edge_second_y} - $signed({seg.sy[CRD_W-1], seg.sy});
    d[5] <= {word.edge_second_z[CRD_W-1], word.edge_second_z} - $signed({seg.sz[CRD_W-1], seg.sz});
  end

  for (genvar e = 0; e < 2; e++) begin : g_end
    for (genvar k = 0; k < 3; k++) begin : g_axis
      localparam int A = (k + 1) % 3;
      localparam int B = (k + 2) % 3;
      always_ff @(posedge clk) begin
        md[3*e+k] <= d[3*e+k] * w[k];
        ma[3*e+k] <= d[3*e+A] * w[B];
        mb[3*e+k] <= d[3*e+B] * w[A];
        crs[3*e+k] <= DOT_W'(ma[3*e+k]) - DOT_W'(mb[3*e+k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    dot1 <= DOT_W'(md[0]) + DOT_W'(md[1]) + DOT_W'(md[2]);
    dot2 <= DOT_W'(md[3]) + DOT_W'(md[4]) + DOT_W'(md[5]);
  end

endmodule

>>> rtl/sem_sq.sv
// sem_sq: squared perpendicular distances from split partial products
// depends on sem_pkg
module sem_sq (
  input  logic                             clk,
  input  logic signed [sem_pkg::DOT_W-1:0] crs [6],
  output logic [sem_pkg::SQ_W-1:0]         perp1,
  output logic [sem_pkg::SQ_W-1:0]         perp2
);
  import sem_pkg::*;

  logic signed [69:0] hh [6];
  logic signed [67:0] hl [6];
  logic [63:0] ll [6];
  logic signed [SQ_W-1:0] sq [6];

  for (genvar i = 0; i < 6; i++) begin : g_comp
    logic signed [34:0] hi_part;
    logic signed [32:0] lo_part;
    logic signed [SQ_W-1:0] thh, thl;
    assign hi_part = crs[i][DOT_W-1:32];
    assign lo_part = {1'b0, crs[i][31:0]};
    always_comb begin
      thh = hh[i];
      thl = hl[i];
    end
    always_ff @(posedge clk) begin
      hh[i] <= hi_part * hi_part;
      hl[i] <= hi_part * lo_part;
      ll[i] <= crs[i][31:0] * crs[i][31:0];
      sq[i] <= (thh <<< 64) + (thl <<< 33) + $signed({72'b0, ll[i]});
    end
  end

  always_ff @(posedge clk) begin
    perp1 <= SQ_W'(sq[0] + sq[1] + sq[2]);
    perp2 <= SQ_W'(sq[3] + sq[4] + sq[5]);
  end

endmodule

>>> rtl/segment_edge_matcher.sv
// segment_edge_matcher: top level, valid line, bound compares and result word
// depends on sem_pkg, sem_cfg, sem_proj, sem_sq
//
// Use: write the segment end points, tolerance and material through the
// cfg_valid/cfg_ready channel (cfg_index picks the register, cfg_data the
// value), then stream edge words: a word is taken at each rising edge with
// start high and busy low. Every word gives one result word on result,
// marked by done for exactly one cycle; the receiver cannot stall.
// The pipeline takes one edge per cycle and never stalls; each edge runs
// through the chain of 33x33 products, cross-product squaring in split
// partial products, and the final 136-bit compares.
// Derived bounds follow a register write through the sem_cfg pipeline, so
// the user makes writes while no edge is in flight; the block does not check.
// Reset (rst, synchronous) clears the registers to their reset values and
// empties the pipeline; busy is high and cfg_ready low while rst is high.
module segment_edge_matcher (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sem_pkg::edge_word_t       seg_edge,
  output logic                      done,
  output sem_pkg::result_word_t     result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sem_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import sem_pkg::*;

  sem_seg_t seg;
  sem_bnd_t bnd;
  logic [MAT_W-1:0] material;
  logic signed [DOT_W-1:0] dot1, dot2;
  logic signed [DOT_W-1:0] crs [6];
  logic [SQ_W-1:0] perp1, perp2;
  logic [5:0] vld;
  logic [NODE_ID_BITS-1:0] ida [6];
  logic [NODE_ID_BITS-1:0] idb [6];
  logic signed [DOT_W-1:0] dl1 [3];
  logic signed [DOT_W-1:0] dl2 [3];
  logic signed [SD_W-1:0] sd1, sd2;
  logic ok, swap;

  assign busy = rst;
  assign cfg_ready = ~rst;

  sem_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .seg      (seg),
    .bnd      (bnd),
    .material (material)
  );

  sem_proj u_proj (
    .clk  (clk),
    .seg  (seg),
    .word (seg_edge),
    .dot1 (dot1),
    .dot2 (dot2),
    .crs  (crs)
  );

  sem_sq u_sq (
    .clk   (clk),
    .crs   (crs),
    .perp1 (perp1),
    .perp2 (perp2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[4:0], start & ~busy};
      done <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    ida[0] <= seg_edge.edge_first_id;
    idb[0] <= seg_edge.edge_second_id;
    for (int i = 1; i < 6; i++) begin
      ida[i] <= ida[i-1];
      idb[i] <= idb[i-1];
    end
    dl1[0] <= dot1;
    dl2[0] <= dot2;
    for (int i = 1; i < 3; i++) begin
      dl1[i] <= dl1[i-1];
      dl2[i] <= dl2[i-1];
    end
  end

  always_comb begin
    sd1 = SD_W'(dl1[2]) <<< QF;
    sd2 = SD_W'(dl2[2]) <<< QF;
    ok = !bnd.norm_zero
      && (perp1 < SQ_W'(bnd.tsqn)) && (perp2 < SQ_W'(bnd.tsqn))
      && ($signed(bnd.lo) <= sd1) && (sd1 <= $signed(bnd.hi))
      && ($signed(bnd.lo) < sd2) && (sd2 <= $signed(bnd.hi));
    swap = dl2[2] < dl1[2];
  end

  always_ff @(posedge clk) begin
    result.matched <= ok;
    result.line_start_id <= !ok ? '0 : (swap ? idb[5] : ida[5]);
    result.line_end_id <= !ok ? '0 : (swap ? ida[5] : idb[5]);
    result.line_material <= ok ? material : '0;
  end

`ifndef SYNTHESIS
  a_done_follows_stage : assert property (@(posedge clk) disable iff (rst)
    vld[5] |=> done)
    else $error("result word lost at the output stage");
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> vld[0])
    else $error("accepted edge word not in the pipeline");
  a_nomatch_clear : assert property (@(posedge clk)
    (done && !result.matched) |-> (result.line_start_id == '0 && result.line_material == '0))
    else $error("unmatched word carries ids or material");
`endif

endmodule

>>> bench/segment_edge_matcher_tb.sv
// segment_edge_matcher_tb: self-checking bench for the segment edge matcher
// depends on sem_pkg and segment_edge_matcher; exact wide-integer prediction of
// every result word, directed edge cases then random segments and edges
module segment_edge_matcher_tb;
  import sem_pkg::*;

  typedef logic signed [191:0] wide_t;
  localparam longint Q_ONE = 65536;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  edge_word_t seg_edge = '0;
  logic done;
  result_word_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // bench copy of the registers
  logic signed [31:0] seg_s [3];
  logic signed [31:0] seg_e [3];
  logic [TOL_W-1:0] tol_q;
  logic [MAT_W-1:0] mat_q;

  result_word_t pending_words [$];
  int mismatches = 0;
  int cycles = 0;

  segment_edge_matcher uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .seg_edge(seg_edge),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic result_word_t match_edge(edge_word_t ew);
    wide_t w [3];
    wide_t d1 [3];
    wide_t d2 [3];
    wide_t c1 [3];
    wide_t c2 [3];
    wide_t norm, dot1, dot2, p1, p2, tol, tsqn, lo, hi, sd1, sd2;
    logic signed [31:0] p1c [3];
    logic signed [31:0] p2c [3];
    result_word_t r;
    p1c[0] = ew.edge_first_x;  p1c[1] = ew.edge_first_y;  p1c[2] = ew.edge_first_z;
    p2c[0] = ew.edge_second_x; p2c[1] = ew.edge_second_y; p2c[2] = ew.edge_second_z;
    for (int k = 0; k < 3; k++) begin
      w[k] = wide_t'(seg_e[k]) - wide_t'(seg_s[k]);
      d1[k] = wide_t'(p1c[k]) - wide_t'(seg_s[k]);
      d2[k] = wide_t'(p2c[k]) - wide_t'(seg_s[k]);
    end
    c1[0] = d1[1] * w[2] - d1[2] * w[1];
    c1[1] = d1[2] * w[0] - d1[0] * w[2];
    c1[2] = d1[0] * w[1] - d1[1] * w[0];
    c2[0] = d2[1] * w[2] - d2[2] * w[1];
    c2[1] = d2[2] * w[0] - d2[0] * w[2];
    c2[2] = d2[0] * w[1] - d2[1] * w[0];
    norm = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
    dot1 = w[0] * d1[0] + w[1] * d1[1] + w[2] * d1[2];
    dot2 = w[0] * d2[0] + w[1] * d2[1] + w[2] * d2[2];
    p1 = c1[0] * c1[0] + c1[1] * c1[1] + c1[2] * c1[2];
    p2 = c2[0] * c2[0] + c2[1] * c2[1] + c2[2] * c2[2];
    tol = wide_t'({1'b0, tol_q});
    tsqn = tol * tol * norm;
    lo = -(tol * norm);
    hi = (wide_t'(Q_ONE) + tol) * norm;
    sd1 = dot1 * wide_t'(Q_ONE);
    sd2 = dot2 * wide_t'(Q_ONE);
    r = '0;
    if (norm != 0 && p1 < tsqn && p2 < tsqn && lo <= sd1 && sd1 <= hi
        && lo < sd2 && sd2 <= hi) begin
      r.matched = 1'b1;
      if (dot2 < dot1) begin
        r.line_start_id = ew.edge_second_id;
        r.line_end_id = ew.edge_first_id;
      end else begin
        r.line_start_id = ew.edge_first_id;
        r.line_end_id = ew.edge_second_id;
      end
      r.line_material = mat_q;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", result);
      end else begin
        want = pending_words.pop_front();
        if (result.matched !== want.matched || result.line_start_id !== want.line_start_id
            || result.line_end_id !== want.line_end_id
            || result.line_material !== want.line_material) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h got %h", want, result);
        end
      end
    end
  end

  // leaves cfg_valid high, the caller drops it after the last write
  task automatic cfg_write(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_X: seg_s[0] = value;
      REG_START_Y: seg_s[1] = value;
      REG_START_Z: seg_s[2] = value;
      REG_END_X:   seg_e[0] = value;
      REG_END_Y:   seg_e[1] = value;
      REG_END_Z:   seg_e[2] = value;
      REG_TOL:     tol_q = value[TOL_W-1:0];
      REG_MAT:     mat_q = value[MAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // waits for the pipeline to drain, then writes the registers
  task automatic set_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                             logic [31:0] tol, logic [31:0] mat);
    drain();
    cfg_write(REG_START_X, sx);
    cfg_write(REG_START_Y, sy);
    cfg_write(REG_START_Z, sz);
    cfg_write(REG_END_X, ex);
    cfg_write(REG_END_Y, ey);
    cfg_write(REG_END_Z, ez);
    cfg_write(REG_TOL, tol);
    cfg_write(REG_MAT, mat);
    cfg_valid <= 1'b0;
    repeat (10) @(posedge clk);
  endtask

  task automatic send_edge(edge_word_t ew, bit idle_gaps);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    seg_edge <= ew;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_words = {pending_words, match_edge(ew)};
  endtask

  function automatic edge_word_t make_edge(int ax, int ay, int az, int bx, int by, int bz);
    edge_word_t ew;
    ew.edge_first_id = NODE_ID_BITS'($urandom);
    ew.edge_second_id = NODE_ID_BITS'($urandom);
    ew.edge_first_x = ax; ew.edge_first_y = ay; ew.edge_first_z = az;
    ew.edge_second_x = bx; ew.edge_second_y = by; ew.edge_second_z = bz;
    return ew;
  endfunction

  // point at parameter t (raw Q16.16) along the segment plus an offset
  function automatic longint seg_point(int k, longint t, longint off);
    return longint'(seg_s[k]) + ((longint'(seg_e[k]) - longint'(seg_s[k])) * t) / Q_ONE + off;
  endfunction

  task automatic test_reset_defaults();
    seg_s = '{0, 0, 0};
    seg_e = '{0, 0, 0};
    tol_q = TOL_RESET;
    mat_q = '0;
    // zero-length segment after reset
    send_edge(make_edge(0, 0, 0, 0, 0, 0), 1'b0);
    send_edge(make_edge(1, 2, 3, -1, -2, -3), 1'b0);
  endtask

  task automatic test_bounds();
    int t;
    t = 1000;
    set_segment(0, 0, 0, 65536, 0, 0, t, 16'hFFFF);
    send_edge(make_edge(0, 0, 0, 65536, 0, 0), 1'b0);
    send_edge(make_edge(65536, 0, 0, 0, 0, 0), 1'b0);
    // lower bound inclusive for the first point, exclusive for the second
    send_edge(make_edge(-t, 0, 0, 30000, 0, 0), 1'b0);
    send_edge(make_edge(30000, 0, 0, -t, 0, 0), 1'b0);
    send_edge(make_edge(-t - 1, 0, 0, 30000, 0, 0), 1'b0);
    send_edge(make_edge(65536 + t, 0, 0, 30000, 0, 0), 1'b0);
    send_edge(make_edge(30000, 0, 0, 65537 + t, 0, 0), 1'b0);
    // distance just below and at the tolerance
    send_edge(make_edge(100, t - 1, 0, 200, 0, t - 1), 1'b0);
    send_edge(make_edge(100, t, 0, 200, 0, 0), 1'b0);
    send_edge(make_edge(100, 0, 0, 200, 0, -t), 1'b0);
    // perpendicular edge: no swap
    send_edge(make_edge(500, 10, 0, 500, -10, 0), 1'b0);
    send_edge(make_edge(500, 0, 0, 500, 0, 0), 1'b0);
    set_segment(0, 0, 0, 65536, 0, 0, 0, 16'h1234);
    send_edge(make_edge(0, 0, 0, 65536, 0, 0), 1'b0);
    send_edge(make_edge(100, 0, 0, 200, 0, 0), 1'b0);
  endtask

  task automatic test_extremes();
    int mn, mx;
    mn = 32'h80000000;
    mx = 32'h7FFFFFFF;
    set_segment(mn, mn, mn, mx, mx, mx, 32'h7FFFFFFF, 16'hFFFF);
    send_edge(make_edge(mn, mn, mn, mx, mx, mx), 1'b0);
    send_edge(make_edge(mx, mx, mx, mn, mn, mn), 1'b0);
    send_edge(make_edge(mx, mn, mx, mn, mx, mn), 1'b0);
    send_edge(make_edge(0, 0, 0, -1, -1, -1), 1'b0);
    set_segment(mx, mn, 0, mn, mx, 0, 32'h7FFFFFFF, 16'h0001);
    send_edge(make_edge(mx, mn, 0, mn, mx, 0), 1'b0);
    send_edge(make_edge(mn, mx, mx, mx, mn, mn), 1'b0);
    set_segment(mx, mx, mx, mx, mx, mx, 32'h7FFFFFFF, 16'h00FF);
    send_edge(make_edge(mx, mx, mx, mx, mx, mx), 1'b0);
  endtask

  task automatic test_random();
    int tol, sx, sy, sz;
    longint t1, t2, o;
    edge_word_t ew;
    for (int ph = 0; ph < 6; ph++) begin
      tol = (ph == 5) ? $urandom_range(1, 8) : $urandom_range(1, 1 << (8 + 2 * ph));
      sx = int'($urandom) >>> 7;
      sy = int'($urandom) >>> 7;
      sz = int'($urandom) >>> 7;
      set_segment(sx, sy, sz, sx + (int'($urandom) >>> 11), sy + (int'($urandom) >>> 11),
                  sz + (int'($urandom) >>> 11), tol, $urandom);
      for (int i = 0; i < 80; i++) begin
        if (i == 40) drain();
        if ($urandom_range(0, 3) == 0) begin
          ew = make_edge($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
          t1 = longint'($urandom_range(0, 65536 + 4 * tol)) - 2 * tol;
          t2 = longint'($urandom_range(0, 65536 + 4 * tol)) - 2 * tol;
          o = tol;
          ew = make_edge(
            int'(seg_point(0, t1, $urandom_range(0, 2 * o) - o) & 32'hFFFFFFFF),
            int'(seg_point(1, t1, $urandom_range(0, o) - o / 2) & 32'hFFFFFFFF),
            int'(seg_point(2, t1, $urandom_range(0, o) - o / 2) & 32'hFFFFFFFF),
            int'(seg_point(0, t2, $urandom_range(0, o) - o / 2) & 32'hFFFFFFFF),
            int'(seg_point(1, t2, $urandom_range(0, 2 * o) - o) & 32'hFFFFFFFF),
            int'(seg_point(2, t2, $urandom_range(0, o) - o / 2) & 32'hFFFFFFFF));
        end
        send_edge(ew, ($urandom_range(0, 3) != 0) && (i < 60));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_bounds();
    test_extremes();
    test_random();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sem_pkg.sv
rtl/sem_cfg.sv
rtl/sem_proj.sv
rtl/sem_sq.sv
rtl/segment_edge_matcher.sv
bench/segment_edge_matcher_tb.sv
